// ===== hdl/lcd4_pkg.sv =====
`default_nettype none
package lcd4_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_POWERUP_WAIT       = 3'd0,
    REG_ENABLE_HIGH_TIME   = 3'd1,
    REG_ENABLE_SETTLE_TIME = 3'd2,
    REG_LONG_COMMAND_WAIT  = 3'd3,
    REG_WAKE_FIRST_WAIT    = 3'd4,
    REG_WAKE_LATER_WAIT    = 3'd5,
    REG_MODE_SWITCH_WAIT   = 3'd6,
    REG_INIT_CLEAR_WAIT    = 3'd7
  } cfg_reg_t;

  // Request codes
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CMD    = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_CURSOR = 2'd3
  } act_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 20;
  localparam int CntW = 20;

  typedef logic [CntW-1:0] cnt_t;
  localparam cnt_t CNT_MAX = 20'hFFFFF;

  // Reset values of the timing registers (in ticks)
  localparam logic [19:0] RST_POWERUP_WAIT       = 20'd20000;
  localparam logic [9:0]  RST_ENABLE_HIGH_TIME   = 10'd1;
  localparam logic [9:0]  RST_ENABLE_SETTLE_TIME = 10'd50;
  localparam logic [19:0] RST_LONG_COMMAND_WAIT  = 20'd2000;
  localparam logic [19:0] RST_WAKE_FIRST_WAIT    = 20'd5000;
  localparam logic [19:0] RST_WAKE_LATER_WAIT    = 20'd125000;
  localparam logic [19:0] RST_MODE_SWITCH_WAIT   = 20'd150;
  localparam logic [19:0] RST_INIT_CLEAR_WAIT    = 20'd5000;

  // LCD command bytes and nibbles
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;

  // Sequencer steps
  typedef logic [3:0] step_t;
  localparam step_t STEP_POWERUP     = 4'd0;
  localparam step_t STEP_WAKE_FIRST  = 4'd1;
  localparam step_t STEP_WAKE_SECOND = 4'd2;
  localparam step_t STEP_WAKE_THIRD  = 4'd3;
  localparam step_t STEP_MODE        = 4'd4;
  localparam step_t STEP_FIRST_CMD   = 4'd5;
  localparam step_t STEP_DISP_OFF    = 4'd6;
  localparam step_t STEP_CLEAR       = 4'd7;
  localparam step_t STEP_ENTRY       = 4'd8;
  localparam step_t STEP_LAST_INIT   = 4'd9;
  localparam step_t STEP_IDLE        = 4'd10;
  localparam step_t STEP_USER        = 4'd11;

  typedef struct packed {
    logic [19:0] powerup_wait;
    logic [9:0]  enable_high_time;
    logic [9:0]  enable_settle_time;
    logic [19:0] long_command_wait;
    logic [19:0] wake_first_wait;
    logic [19:0] wake_later_wait;
    logic [19:0] mode_switch_wait;
    logic [19:0] init_clear_wait;
  } lcd4_cfg_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       accepted;
  } lcd4_res_t;

  // Init command table, steps 5..9
  function automatic logic [7:0] init_cmd(step_t s);
    logic [7:0] b;
    begin
      unique case (s)
        STEP_FIRST_CMD: b = CMD_FUNC_SET;
        STEP_DISP_OFF:  b = CMD_DISP_OFF;
        STEP_CLEAR:     b = CMD_CLEAR;
        STEP_ENTRY:     b = CMD_ENTRY;
        default:        b = CMD_DISP_ON;
      endcase
      return b;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lcd4_cfg_regs.sv =====
`default_nettype none
module lcd4_cfg_regs
  import lcd4_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output lcd4_cfg_t                cfg
);

  // Always ready: a write is registered whenever cfg_valid is high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.powerup_wait       <= RST_POWERUP_WAIT;
      cfg.enable_high_time   <= RST_ENABLE_HIGH_TIME;
      cfg.enable_settle_time <= RST_ENABLE_SETTLE_TIME;
      cfg.long_command_wait  <= RST_LONG_COMMAND_WAIT;
      cfg.wake_first_wait    <= RST_WAKE_FIRST_WAIT;
      cfg.wake_later_wait    <= RST_WAKE_LATER_WAIT;
      cfg.mode_switch_wait   <= RST_MODE_SWITCH_WAIT;
      cfg.init_clear_wait    <= RST_INIT_CLEAR_WAIT;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POWERUP_WAIT:       cfg.powerup_wait       <= cfg_data;
        REG_ENABLE_HIGH_TIME:   cfg.enable_high_time   <= cfg_data[9:0];
        REG_ENABLE_SETTLE_TIME: cfg.enable_settle_time <= cfg_data[9:0];
        REG_LONG_COMMAND_WAIT:  cfg.long_command_wait  <= cfg_data;
        REG_WAKE_FIRST_WAIT:    cfg.wake_first_wait    <= cfg_data;
        REG_WAKE_LATER_WAIT:    cfg.wake_later_wait    <= cfg_data;
        REG_MODE_SWITCH_WAIT:   cfg.mode_switch_wait   <= cfg_data;
        REG_INIT_CLEAR_WAIT:    cfg.init_clear_wait    <= cfg_data;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lcd4_seq.sv =====
`default_nettype none
module lcd4_seq
  import lcd4_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [1:0] action,
  input  wire logic [7:0] byte_value,
  input  wire logic       row,
  input  wire logic [3:0] col,
  input  wire lcd4_cfg_t  cfg,
  output lcd4_res_t       res
);

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_HIGH   = 2'd1,
    PH_SETTLE = 2'd2,
    PH_EXTRA  = 2'd3
  } phase_t;

  typedef struct packed {
    step_t      step;
    phase_t     phase;
    cnt_t       cnt;
    logic [7:0] pending;
    logic       low_next;
    logic       long_due;
    logic       rs;
    logic       en;
    logic [3:0] nibble;
  } seq_t;

  // A zero-length wait can chain at most three phase ends in one tick
  localparam int ChainDepth = 3;

  seq_t st;
  seq_t st_next;
  logic acc;

  function automatic seq_t load_byte(seq_t s, logic [7:0] b, logic rs);
    seq_t r;
    begin
      r = s;
      r.pending  = b;
      r.rs       = rs;
      r.nibble   = b[7:4];
      r.en       = 1'b1;
      r.phase    = PH_HIGH;
      r.cnt      = '0;
      r.low_next = 1'b1;
      r.long_due = !rs && (b == CMD_CLEAR || b == CMD_HOME);
      return r;
    end
  endfunction

  function automatic seq_t start_step(seq_t s, step_t n);
    seq_t r;
    begin
      r = s;
      r.step = n;
      r.cnt  = '0;
      if (n >= STEP_WAKE_FIRST && n <= STEP_MODE) begin
        r.nibble   = (n == STEP_MODE) ? NIB_4BIT : NIB_WAKE;
        r.rs       = 1'b0;
        r.en       = 1'b1;
        r.phase    = PH_HIGH;
        r.low_next = 1'b0;
        r.long_due = 1'b0;
      end else if (n >= STEP_FIRST_CMD && n <= STEP_LAST_INIT) begin
        r = load_byte(r, init_cmd(n), 1'b0);
      end else begin
        r.step     = STEP_IDLE;
        r.phase    = PH_WAIT;
        r.en       = 1'b0;
        r.low_next = 1'b0;
        r.long_due = 1'b0;
      end
      return r;
    end
  endfunction

  // Elapsed count has reached the length of the current phase
  function automatic logic phase_done(seq_t s, lcd4_cfg_t c);
    logic [19:0] hi;
    logic [19:0] se;
    logic [19:0] ex;
    logic        done;
    begin
      hi = (c.enable_high_time == '0) ? 20'd1 : {10'd0, c.enable_high_time};
      se = (c.enable_settle_time == '0) ? 20'd1 : {10'd0, c.enable_settle_time};
      if (s.long_due) begin
        ex = c.long_command_wait;
      end else if (s.step == STEP_WAKE_FIRST) begin
        ex = c.wake_first_wait;
      end else if (s.step == STEP_WAKE_SECOND || s.step == STEP_WAKE_THIRD) begin
        ex = c.wake_later_wait;
      end else if (s.step == STEP_MODE) begin
        ex = c.mode_switch_wait;
      end else if (s.step == STEP_CLEAR) begin
        ex = c.init_clear_wait;
      end else begin
        ex = '0;
      end
      unique case (s.phase)
        PH_WAIT:   done = (s.step == STEP_POWERUP) && (s.cnt >= c.powerup_wait);
        PH_HIGH:   done = (s.cnt >= hi);
        PH_SETTLE: done = (s.cnt >= se);
        default:   done = (s.cnt >= ex);
      endcase
      return done;
    end
  endfunction

  function automatic seq_t finish_phase(seq_t s);
    seq_t r;
    begin
      r = s;
      r.cnt = '0;
      unique case (s.phase)
        PH_WAIT: begin
          r = start_step(r, STEP_WAKE_FIRST);
        end
        PH_HIGH: begin
          r.en    = 1'b0;
          r.phase = PH_SETTLE;
        end
        PH_SETTLE: begin
          if (s.low_next) begin
            r.low_next = 1'b0;
            r.nibble   = s.pending[3:0];
            r.en       = 1'b1;
            r.phase    = PH_HIGH;
          end else begin
            r.phase = PH_EXTRA;
          end
        end
        default: begin
          if (s.long_due) begin
            r.long_due = 1'b0;
          end else if (s.step >= STEP_LAST_INIT) begin
            r = start_step(r, STEP_IDLE);
          end else begin
            r = start_step(r, s.step + 4'd1);
          end
        end
      endcase
      return r;
    end
  endfunction

  // Next state for one item: take a request when idle, else advance one tick
  always_comb begin
    logic [7:0] cursor;
    cursor  = CMD_SET_DDRAM | ((row ? ROW1_OFFSET : 8'h00) + {4'd0, col});
    st_next = st;
    acc     = 1'b0;
    if (fire) begin
      if (act_t'(action) != ACT_TICK && st.step == STEP_IDLE) begin
        acc = 1'b1;
        st_next.step = STEP_USER;
        unique case (act_t'(action))
          ACT_DATA:   st_next = load_byte(st_next, byte_value, 1'b1);
          ACT_CURSOR: st_next = load_byte(st_next, cursor, 1'b0);
          default:    st_next = load_byte(st_next, byte_value, 1'b0);
        endcase
      end else if (st.step != STEP_IDLE) begin
        if (st.cnt != CNT_MAX) begin
          st_next.cnt = st.cnt + 20'd1;
        end
        for (int i = 0; i < ChainDepth; i++) begin
          if (st_next.step != STEP_IDLE && phase_done(st_next, cfg)) begin
            st_next = finish_phase(st_next);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.step     <= STEP_POWERUP;
      st.phase    <= PH_WAIT;
      st.cnt      <= '0;
      st.pending  <= '0;
      st.low_next <= 1'b0;
      st.long_due <= 1'b0;
      st.rs       <= 1'b0;
      st.en       <= 1'b0;
      st.nibble   <= '0;
    end else begin
      st <= st_next;
    end
  end

  // Pin levels after this item
  always_comb begin
    res.reg_select  = st_next.rs;
    res.enable      = st_next.en;
    res.data_nibble = st_next.nibble;
    res.busy_res    = (st_next.step != STEP_IDLE);
    res.accepted    = acc;
  end

endmodule
`default_nettype wire

// ===== hdl/char_lcd_4bit_write_controller.sv =====
// Character LCD controller, write-only 4-bit bus (RS, EN, D7..D4).
// Input channel (in_valid/in_stall) carries one item per microsecond tick:
// action 0 is a plain tick, 1 a command byte, 2 a data byte, 3 a cursor move
// to row/col. Each item yields exactly one result on the output channel
// (out_valid/out_stall): the pin levels after that tick, busy_res, and
// accepted, which is 1 when a request found the controller idle.
// Results pass through the input register, then the sequencer and result
// register. One item per cycle is sustained while out_stall is low; the
// sequencer updates its state once per item in a single pass.
// A stalled result holds in the output register while the input register
// still takes one more item; in_stall rises only when both are full.
// Timing registers are written over cfg_valid/cfg_ready (always ready) with
// cfg_index selecting the register; write them only while idle.
// Reset (rst, synchronous) restores default timings and restarts the
// power-up sequence: wait, wake-up nibbles 3,3,3,2, then 0x28, 0x08, 0x01,
// 0x06, 0x0C. busy_res stays 1 until that sequence is done.
`default_nettype none
module char_lcd_4bit_write_controller
  import lcd4_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          action,
  input  wire logic [7:0]          byte_value,
  input  wire logic                row,
  input  wire logic [3:0]          col,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     reg_select,
  output logic                     enable,
  output logic [3:0]               data_nibble,
  output logic                     busy_res,
  output logic                     accepted,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  lcd4_cfg_t  cfg;
  lcd4_res_t  res;
  lcd4_res_t  res_q;
  logic       in_q_valid;
  logic [1:0] action_q;
  logic [7:0] byte_q;
  logic       row_q;
  logic [3:0] col_q;
  logic       advance;

  lcd4_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Item moves from input register to result register
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && out_valid && out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      action_q <= action;
      byte_q   <= byte_value;
      row_q    <= row;
      col_q    <= col;
    end
  end

  lcd4_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .action     (action_q),
    .byte_value (byte_q),
    .row        (row_q),
    .col        (col_q),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign reg_select  = res_q.reg_select;
  assign enable      = res_q.enable;
  assign data_nibble = res_q.data_nibble;
  assign busy_res    = res_q.busy_res;
  assign accepted    = res_q.accepted;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lcd4_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 120;
  localparam int IDLE_PCT = 27;

  typedef enum logic [1:0] {
    SEQ_WAIT    = 2'd0,
    SEQ_EN_HIGH = 2'd1,
    SEQ_SETTLE  = 2'd2,
    SEQ_EXTRA   = 2'd3
  } seq_phase_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] value;
    logic       row_sel;
    logic [3:0] col_sel;
  } lcd_req_t;

  // DUT pins, all driven from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] action = '0;
  logic [7:0] byte_value = '0;
  logic row = 1'b0;
  logic [3:0] col = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  logic reg_select, enable, busy_res, accepted;
  logic [3:0] data_nibble;

  char_lcd_4bit_write_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .byte_value(byte_value), .row(row), .col(col),
    .out_valid(out_valid), .out_stall(out_stall),
    .reg_select(reg_select), .enable(enable), .data_nibble(data_nibble),
    .busy_res(busy_res), .accepted(accepted),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending requests and expected pin levels
  lcd_req_t req_q[$];
  lcd4_res_t expected_pins[$];
  int reqs_queued = 0;
  int reqs_taken = 0;
  int errors = 0;
  logic hold_off_req = 1'b0;
  logic steady = 1'b0;

  // Controller model state
  lcd4_cfg_t timing = '{
    powerup_wait: RST_POWERUP_WAIT,
    enable_high_time: RST_ENABLE_HIGH_TIME,
    enable_settle_time: RST_ENABLE_SETTLE_TIME,
    long_command_wait: RST_LONG_COMMAND_WAIT,
    wake_first_wait: RST_WAKE_FIRST_WAIT,
    wake_later_wait: RST_WAKE_LATER_WAIT,
    mode_switch_wait: RST_MODE_SWITCH_WAIT,
    init_clear_wait: RST_INIT_CLEAR_WAIT
  };
  step_t seq_step = STEP_POWERUP;
  seq_phase_t seq_phase = SEQ_WAIT;
  cnt_t phase_ticks = '0;
  logic [7:0] out_byte = '0;
  logic low_nibble_due = 1'b0;
  logic long_pause_due = 1'b0;
  logic rs_pin = 1'b0;
  logic en_pin = 1'b0;
  logic [3:0] nib_pin = '0;
  logic [7:0] bringup_cmds [0:4] = '{CMD_FUNC_SET, CMD_DISP_OFF, CMD_CLEAR, CMD_ENTRY,
                                     CMD_DISP_ON};

  // Extra wait after the wake-up nibbles and the power-up clear
  function automatic logic [31:0] extra_ticks();
    if (seq_step == STEP_WAKE_FIRST) return {12'd0, timing.wake_first_wait};
    if (seq_step > STEP_WAKE_FIRST && seq_step < STEP_MODE)
      return {12'd0, timing.wake_later_wait};
    if (seq_step == STEP_MODE) return {12'd0, timing.mode_switch_wait};
    if (seq_step == STEP_CLEAR) return {12'd0, timing.init_clear_wait};
    return 32'd0;
  endfunction

  // Length of the current phase; zero pulse times count as one tick
  function automatic logic [31:0] phase_limit();
    case (seq_phase)
      SEQ_WAIT:
        return (seq_step == STEP_POWERUP) ? {12'd0, timing.powerup_wait} : 32'hFFFF_FFFF;
      SEQ_EN_HIGH:
        return (timing.enable_high_time == 0) ? 32'd1 : {22'd0, timing.enable_high_time};
      SEQ_SETTLE:
        return (timing.enable_settle_time == 0) ? 32'd1 : {22'd0, timing.enable_settle_time};
      default:
        return long_pause_due ? {12'd0, timing.long_command_wait} : extra_ticks();
    endcase
  endfunction

  function automatic void send_byte(logic [7:0] b, logic rs_v);
    out_byte = b;
    rs_pin = rs_v;
    nib_pin = b[7:4];
    en_pin = 1'b1;
    seq_phase = SEQ_EN_HIGH;
    phase_ticks = '0;
    low_nibble_due = 1'b1;
    long_pause_due = !rs_v && (b == CMD_CLEAR || b == CMD_HOME);
  endfunction

  function automatic void enter_step(step_t s);
    seq_step = s;
    phase_ticks = '0;
    if (s >= STEP_WAKE_FIRST && s <= STEP_MODE) begin
      nib_pin = (s == STEP_MODE) ? NIB_4BIT : NIB_WAKE;
      rs_pin = 1'b0;
      en_pin = 1'b1;
      seq_phase = SEQ_EN_HIGH;
      low_nibble_due = 1'b0;
      long_pause_due = 1'b0;
    end else if (s >= STEP_FIRST_CMD && s <= STEP_LAST_INIT) begin
      send_byte(bringup_cmds[s - STEP_FIRST_CMD], 1'b0);
    end else begin
      seq_step = STEP_IDLE;
      seq_phase = SEQ_WAIT;
      en_pin = 1'b0;
      low_nibble_due = 1'b0;
      long_pause_due = 1'b0;
    end
  endfunction

  function automatic void close_phase();
    phase_ticks = '0;
    case (seq_phase)
      SEQ_WAIT: enter_step(STEP_WAKE_FIRST);
      SEQ_EN_HIGH: begin
        en_pin = 1'b0;
        seq_phase = SEQ_SETTLE;
      end
      SEQ_SETTLE: begin
        if (low_nibble_due) begin
          low_nibble_due = 1'b0;
          nib_pin = out_byte[3:0];
          en_pin = 1'b1;
          seq_phase = SEQ_EN_HIGH;
        end else begin
          seq_phase = SEQ_EXTRA;
        end
      end
      default: begin
        if (long_pause_due) long_pause_due = 1'b0;
        else if (seq_step >= STEP_LAST_INIT) enter_step(STEP_IDLE);
        else enter_step(seq_step + step_t'(1));
      end
    endcase
  endfunction

  // One microsecond; zero-length phases fall through in the same tick
  function automatic void advance_tick();
    int guard;
    if (seq_step == STEP_IDLE) return;
    if (phase_ticks < CNT_MAX) phase_ticks++;
    guard = 0;
    while (guard < 8 && seq_step != STEP_IDLE && {12'd0, phase_ticks} >= phase_limit()) begin
      close_phase();
      guard++;
    end
  endfunction

  function automatic lcd4_res_t predict_pins(act_t a, logic [7:0] b, logic r, logic [3:0] c);
    lcd4_res_t res;
    logic took;
    took = (a != ACT_TICK) && (seq_step == STEP_IDLE);
    if (took) begin
      seq_step = STEP_USER;
      case (a)
        ACT_CMD: send_byte(b, 1'b0);
        ACT_DATA: send_byte(b, 1'b1);
        default: send_byte(CMD_SET_DDRAM | ((r ? ROW1_OFFSET : 8'h00) + {4'h0, c}), 1'b0);
      endcase
    end else begin
      advance_tick();
    end
    res.reg_select = rs_pin;
    res.enable = en_pin;
    res.data_nibble = nib_pin;
    res.busy_res = (seq_step != STEP_IDLE);
    res.accepted = took;
    return res;
  endfunction

  // Request driver: predicts each transfer as it is taken
  always @(posedge clk) begin : feed
    lcd_req_t nxt;
    logic gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pins.push_back(predict_pins(act_t'(action), byte_value, row, col));
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        gap = !steady && ($urandom_range(99) < IDLE_PCT);
        if (req_q.size() != 0 && !gap) begin
          nxt = req_q.pop_front();
          action <= nxt.act;
          byte_value <= nxt.value;
          row <= nxt.row_sel;
          col <= nxt.col_sel;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [3:0] want_v, logic [3:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Result monitor and receiver stall, with one long hold-off on request
  int hold_left = 0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin : watch
    lcd4_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pins.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = expected_pins.pop_front();
        check_field("reg_select", {3'd0, want.reg_select}, {3'd0, reg_select});
        check_field("enable", {3'd0, want.enable}, {3'd0, enable});
        check_field("data_nibble", want.data_nibble, data_nibble);
        check_field("busy_res", {3'd0, want.busy_res}, {3'd0, busy_res});
        check_field("accepted", {3'd0, want.accepted}, {3'd0, accepted});
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_off_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [19:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POWERUP_WAIT: timing.powerup_wait = val;
      REG_ENABLE_HIGH_TIME: timing.enable_high_time = val[9:0];
      REG_ENABLE_SETTLE_TIME: timing.enable_settle_time = val[9:0];
      REG_LONG_COMMAND_WAIT: timing.long_command_wait = val;
      REG_WAKE_FIRST_WAIT: timing.wake_first_wait = val;
      REG_WAKE_LATER_WAIT: timing.wake_later_wait = val;
      REG_MODE_SWITCH_WAIT: timing.mode_switch_wait = val;
      default: timing.init_clear_wait = val;
    endcase
  endtask

  task automatic push_item(act_t a, logic [7:0] b, logic r, logic [3:0] c);
    lcd_req_t it;
    it.act = a;
    it.value = b;
    it.row_sel = r;
    it.col_sel = c;
    req_q.push_back(it);
    reqs_queued++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_item(ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         4'($urandom_range(15)));
  endtask

  function automatic int pulse_ticks();
    int h, s;
    h = (timing.enable_high_time == 0) ? 1 : int'(timing.enable_high_time);
    s = (timing.enable_settle_time == 0) ? 1 : int'(timing.enable_settle_time);
    return h + s;
  endfunction

  // Ticks a request keeps the bus busy after it is taken
  function automatic int req_ticks(act_t a, logic [7:0] b);
    int n;
    n = 2 * pulse_ticks();
    if (a == ACT_CMD && (b == CMD_CLEAR || b == CMD_HOME)) n += int'(timing.long_command_wait);
    return n;
  endfunction

  // Request plus enough ticks to finish it
  task automatic push_sent(act_t a, logic [7:0] b, logic r, logic [3:0] c);
    push_item(a, b, r, c);
    push_ticks(req_ticks(a, b) + $urandom_range(2));
  endtask

  // Mostly complete request sequences, some noise, some cut short
  task automatic push_random(int count);
    int goal, pick;
    act_t a;
    logic [7:0] b;
    logic r;
    logic [3:0] c;
    goal = reqs_queued + count;
    while (reqs_queued < goal) begin
      a = act_t'($urandom_range(ACT_CMD, ACT_CURSOR));
      b = 8'($urandom_range(255));
      if (a == ACT_CMD && $urandom_range(99) < 20) b = $urandom_range(1) ? CMD_CLEAR : CMD_HOME;
      r = 1'($urandom_range(1));
      c = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 65) begin
        push_sent(a, b, r, c);
      end else if (pick < 85) begin
        push_item(act_t'($urandom_range(ACT_TICK, ACT_CURSOR)), b, r, c);
      end else begin
        push_item(a, b, r, c);
        push_ticks($urandom_range(req_ticks(a, b)));
      end
    end
  endtask

  // Wait out every transfer, tick the bus to idle, then let the pipe empty
  task automatic drain_idle();
    while (reqs_queued != reqs_taken || expected_pins.size() != 0 || seq_step != STEP_IDLE) begin
      if (reqs_queued == reqs_taken && expected_pins.size() == 0) push_ticks(16);
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int boot;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // short power-up, zero pulse times, a mix of zero and nonzero waits
    write_reg(REG_POWERUP_WAIT, 20'd1);
    write_reg(REG_ENABLE_HIGH_TIME, 20'd0);
    write_reg(REG_ENABLE_SETTLE_TIME, 20'd0);
    write_reg(REG_LONG_COMMAND_WAIT, 20'd3);
    write_reg(REG_WAKE_FIRST_WAIT, 20'd0);
    write_reg(REG_WAKE_LATER_WAIT, 20'd2);
    write_reg(REG_MODE_SWITCH_WAIT, 20'd0);
    write_reg(REG_INIT_CLEAR_WAIT, 20'd4);

    // requests during power-up are refused
    boot = int'(timing.powerup_wait) + 14 * pulse_ticks() + int'(timing.wake_first_wait)
         + 2 * int'(timing.wake_later_wait) + int'(timing.mode_switch_wait)
         + int'(timing.long_command_wait) + int'(timing.init_clear_wait);
    push_item(ACT_CMD, CMD_CLEAR, 1'b0, 4'd0);
    push_ticks(5);
    push_item(ACT_DATA, 8'hFF, 1'b1, 4'hF);
    push_item(ACT_CURSOR, 8'h00, 1'b1, 4'hF);
    push_ticks(boot);
    drain_idle();

    // directed requests at idle
    push_item(ACT_TICK, 8'hFF, 1'b1, 4'hF);
    push_sent(ACT_DATA, 8'h00, 1'b0, 4'd0);
    push_sent(ACT_DATA, 8'hFF, 1'b1, 4'hF);
    push_sent(ACT_CMD, CMD_CLEAR, 1'b0, 4'd0);
    push_sent(ACT_CMD, CMD_HOME, 1'b1, 4'hF);
    push_sent(ACT_DATA, CMD_CLEAR, 1'b0, 4'd0);
    push_sent(ACT_DATA, CMD_HOME, 1'b0, 4'd0);
    push_sent(ACT_CURSOR, 8'h00, 1'b0, 4'd0);
    push_sent(ACT_CURSOR, 8'hFF, 1'b1, 4'hF);
    // back-to-back: the second request hits a busy bus
    push_item(ACT_CMD, 8'h3C, 1'b0, 4'd0);
    push_item(ACT_DATA, 8'hC3, 1'b1, 4'd5);
    push_ticks(req_ticks(ACT_CMD, 8'h3C));
    drain_idle();

    // random traffic with short pulses, no extra wait, one long receiver hold-off
    write_reg(REG_ENABLE_HIGH_TIME, 20'($urandom_range(1, 2)));
    write_reg(REG_ENABLE_SETTLE_TIME, 20'($urandom_range(1, 3)));
    write_reg(REG_LONG_COMMAND_WAIT, 20'd0);
    hold_off_req <= 1'b1;
    push_random(130);
    drain_idle();

    // full-scale 20-bit waits; pulse times written with the unused upper bits set
    // long and power-up waits are never reached here
    write_reg(REG_ENABLE_HIGH_TIME, 20'hFFC1E);
    write_reg(REG_ENABLE_SETTLE_TIME, 20'hFFC14);
    write_reg(REG_LONG_COMMAND_WAIT, 20'hFFFFF);
    write_reg(REG_POWERUP_WAIT, 20'hFFFFF);
    write_reg(REG_WAKE_FIRST_WAIT, 20'hFFFFF);
    write_reg(REG_WAKE_LATER_WAIT, 20'hFFFFF);
    write_reg(REG_MODE_SWITCH_WAIT, 20'hFFFFF);
    write_reg(REG_INIT_CLEAR_WAIT, 20'hFFFFF);
    push_item(ACT_DATA, 8'h5A, 1'b1, 4'hA);
    push_item(ACT_CURSOR, 8'hA5, 1'b0, 4'h5);
    push_ticks(req_ticks(ACT_DATA, 8'h5A));
    drain_idle();

    // back-to-back traffic with no idling on either side
    write_reg(REG_ENABLE_HIGH_TIME, 20'd3);
    write_reg(REG_ENABLE_SETTLE_TIME, 20'd1);
    write_reg(REG_LONG_COMMAND_WAIT, 20'($urandom_range(1, 5)));
    steady <= 1'b1;
    push_random(130);
    drain_idle();
    steady <= 1'b0;

    repeat (8) @(posedge clk);
    if (expected_pins.size() != 0) begin
      $error("%0d expected results never arrived", expected_pins.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    int n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lcd4_pkg.sv
hdl/lcd4_cfg_regs.sv
hdl/lcd4_seq.sv
hdl/char_lcd_4bit_write_controller.sv
dv/testbench.sv
